/* hdl/htfa_pkg.sv */
// shared types and constants of the humidity and temperature frame averager
// no dependencies
package htfa_pkg;

    localparam int FRAME_LEN    = 7;
    localparam int SAMPLE_W     = 20;
    localparam int SUM_W        = 22;
    localparam int HUM_W        = 14;
    localparam int TEMP_W       = 15;
    localparam int POS_W        = 3;
    localparam int COUNT_W      = 2;

    localparam logic [COUNT_W-1:0] WINDOW_FULL = 2'd3;
    localparam logic [13:0]        HUM_MUL     = 14'd10000;
    localparam logic [14:0]        TEMP_MUL    = 15'd20000;
    localparam logic [15:0]        DIV3_RECIP  = 16'd43691;
    localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 15'd5000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] humidity;
        logic [SAMPLE_W-1:0] temp;
    } sample_t;

endpackage

/* hdl/htfa_front.sv */
// front end: frames incoming bytes, keeps bytes 1 to 5 and pulls out one sample per frame
// depends on htfa_pkg
module htfa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                push,
    output htfa_pkg::sample_t   sample
);
    import htfa_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos;
    logic             is_last;
    logic [7:0]       fb_reg [0:4];

    always_comb
    begin
        pos      = frame_start ? '0 : pos_reg;
        is_last  = (pos >= POS_W'(FRAME_LEN - 1));
        pos_next = is_last ? '0 : pos + POS_W'(1);
        push     = accept && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos inside {[3'd1:3'd5]}))
        begin
            fb_reg[pos - POS_W'(1)] <= rx_byte;
        end
    end

    always_comb
    begin
        sample.humidity = {fb_reg[0], fb_reg[1], fb_reg[2][7:4]};
        sample.temp     = {fb_reg[2][3:0], fb_reg[3], fb_reg[4]};
    end

endmodule

/* hdl/htfa_queue.sv */
// short sample queue between front and back ends
// depends on htfa_pkg
module htfa_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  htfa_pkg::sample_t   push_data,
    output logic                full,
    input  logic                pop,
    output htfa_pkg::sample_t   pop_data,
    output logic                empty
);
    import htfa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sample_t          mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/htfa_back.sv */
// back end: three-sample window, scaling pipeline and output register
// depends on htfa_pkg
module htfa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  htfa_pkg::sample_t          q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [htfa_pkg::HUM_W-1:0]  out_hum,
    output logic [htfa_pkg::TEMP_W-1:0] out_temp,
    output logic                       out_full
);
    import htfa_pkg::*;

    logic                advance;
    logic [SAMPLE_W-1:0] h_old_reg;
    logic [SAMPLE_W-1:0] h_new_reg;
    logic [SAMPLE_W-1:0] t_old_reg;
    logic [SAMPLE_W-1:0] t_new_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    logic                a_valid_reg;
    logic                a_full_reg;
    logic [SUM_W-1:0]    a_sum_h_reg;
    logic [SUM_W-1:0]    a_sum_t_reg;

    logic                b_valid_reg;
    logic                b_full_reg;
    logic [15:0]         b_q_h_reg;
    logic [15:0]         b_q_t_reg;
    logic [35:0]         prod_h;
    logic [36:0]         prod_t;

    logic [31:0]         div_h;
    logic [31:0]         div_t;
    logic [HUM_W-1:0]    hum_next;
    logic [TEMP_W-1:0]   temp_next;

    logic                out_valid_reg;
    logic                out_full_reg;
    logic [HUM_W-1:0]    out_hum_reg;
    logic [TEMP_W-1:0]   out_temp_reg;

    assign advance    = !out_valid_reg || out_ready;
    assign q_pop      = advance && !q_empty;
    assign count_next = (count_reg == WINDOW_FULL) ? WINDOW_FULL : count_reg + COUNT_W'(1);

    // window update and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_old_reg   <= '0;
            h_new_reg   <= '0;
            t_old_reg   <= '0;
            t_new_reg   <= '0;
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= q_pop;
            if (q_pop)
            begin
                h_old_reg <= h_new_reg;
                h_new_reg <= q_data.humidity;
                t_old_reg <= t_new_reg;
                t_new_reg <= q_data.temp;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_full_reg  <= (count_next == WINDOW_FULL);
            a_sum_h_reg <= SUM_W'(h_old_reg) + SUM_W'(h_new_reg) + SUM_W'(q_data.humidity);
            a_sum_t_reg <= SUM_W'(t_old_reg) + SUM_W'(t_new_reg) + SUM_W'(q_data.temp);
        end
    end

    // scale and drop the 2^20
    assign prod_h = 36'(a_sum_h_reg) * 36'(HUM_MUL);
    assign prod_t = 37'(a_sum_t_reg) * 37'(TEMP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            b_full_reg <= a_full_reg;
            b_q_h_reg  <= prod_h[35:20];
            b_q_t_reg  <= prod_t[35:20];
        end
    end

    // divide by three through the reciprocal, exact below 2^16
    assign div_h     = 32'(b_q_h_reg) * 32'(DIV3_RECIP);
    assign div_t     = 32'(b_q_t_reg) * 32'(DIV3_RECIP);
    assign hum_next  = b_full_reg ? div_h[30:17] : '0;
    assign temp_next = b_full_reg ? (div_t[31:17] - TEMP_OFFSET) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            out_full_reg <= b_full_reg;
            out_hum_reg  <= hum_next;
            out_temp_reg <= temp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hum   = out_hum_reg;
    assign out_temp  = out_temp_reg;
    assign out_full  = out_full_reg;

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == WINDOW_FULL |=> count_reg == WINDOW_FULL)
        else $error("window count left saturation");

    a_zero_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_full_reg |-> out_hum_reg == '0 && out_temp_reg == '0)
        else $error("result not zero while window incomplete");

    a_pop_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> a_valid_reg)
        else $error("popped sample lost from pipeline");
`endif

endmodule

/* hdl/humidity_temp_frame_averager_unit.sv */
// top level of the humidity and temperature frame averager
// depends on htfa_pkg, htfa_front, htfa_queue, htfa_back
//
// takes one sensor frame byte per cycle while the queue is not full, and gives one result
// per seven-byte frame, at its last byte; a byte with tuser set restarts the frame at the
// status byte. humidity and temperature are averaged over the last three frames; until
// three have arrived the result carries a clear ready flag and zero values. the sample
// enters the queue on the edge that takes the last byte; the result passes the window
// sum, constant multiply and divide-by-three registers when nothing stalls downstream;
// a two-entry sample queue lets the byte side keep running while results wait downstream
module humidity_temp_frame_averager_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // humidity_centipct, temp_centideg, zero fill
    output logic        m_tuser    // avg_ready
);
    import htfa_pkg::*;

    logic               accept;
    logic               push;
    sample_t            sample;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    sample_t            q_data;
    logic [HUM_W-1:0]   hum;
    logic [TEMP_W-1:0]  temp;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    htfa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .sample      (sample)
    );

    htfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (sample),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    htfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hum   (hum),
        .out_temp  (temp),
        .out_full  (m_tuser)
    );

    assign m_tdata = {3'b000, temp, hum};

endmodule
